### design/lshc_pkg.sv
`default_nettype none

package lshc_pkg;

  // Held bytes of the lookahead window
  localparam int unsigned LOOKAHEAD = 12;
  localparam int unsigned CNT_W = $clog2(LOOKAHEAD + 1);

  // Keyword and library prefix table
  localparam int unsigned WORD_COUNT = 22;
  localparam int unsigned WORD_MAX = 9;

  typedef enum logic [2:0] {
    CLS_NORMAL  = 3'd0,
    CLS_COMMENT = 3'd2,
    CLS_KEYWORD = 3'd3,
    CLS_STRING  = 3'd4,
    CLS_NUMBER  = 3'd5,
    CLS_LIB     = 3'd7
  } hl_class_e;

  typedef enum logic [3:0] {
    MODE_LEAD    = 4'b0001,
    MODE_SCAN    = 4'b0010,
    MODE_COMMENT = 4'b0100,
    MODE_HALT    = 4'b1000
  } run_mode_e;

  typedef struct packed {
    logic [7:0] quote;
    logic       esc;
    logic       after_sep;
    hl_class_e  prev_cls;
    run_mode_e  mode;
    logic [3:0] kw_rem;
    logic       lib;
  } scan_state_t;

  typedef struct packed {
    logic        ok;
    hl_class_e   cls;
    scan_state_t next;
  } settle_t;

  localparam scan_state_t SCAN_RESET = '{
    quote:     8'h00,
    esc:       1'b0,
    after_sep: 1'b1,
    prev_cls:  CLS_NORMAL,
    mode:      MODE_LEAD,
    kw_rem:    4'd0,
    lib:       1'b0
  };

  // Text is right-justified: first character in the highest used byte
  localparam logic [71:0] WORD_TEXT [WORD_COUNT] = '{
    72'("function"), 72'("if"), 72'("while"), 72'("for"),
    72'("end"), 72'("in"), 72'("do"), 72'("local"),
    72'("break"), 72'("then"), 72'("pairs"), 72'("return"),
    72'("else"), 72'("elseif"), 72'("not"), 72'("and"),
    72'("or"),
    72'("math."), 72'("table."), 72'("string."), 72'("mouse."),
    72'("keyboard.")
  };

  localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
    4'd8, 4'd2, 4'd5, 4'd3, 4'd3, 4'd2, 4'd2, 4'd5,
    4'd5, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd3, 4'd3,
    4'd2,
    4'd5, 4'd6, 4'd7, 4'd6, 4'd9
  };

  // Library prefixes are the last five entries
  localparam logic [WORD_COUNT-1:0] WORD_LIB = 22'h3E0000;

  function automatic logic [7:0] word_char(input int unsigned idx, input int unsigned pos);
    int unsigned len;
    logic [7:0]  ch;
    len = int'(WORD_LEN[idx]);
    ch = 8'h00;
    if (pos < len) begin
      ch = WORD_TEXT[idx][8 * (len - 1 - pos) +: 8];
    end
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h00) || is_space(c) ||
           (c == ",") || (c == ".") || (c == "(") || (c == ")") ||
           (c == "+") || (c == "-") || (c == "/") || (c == "*") ||
           (c == "=") || (c == "~") || (c == "%") || (c == "[") ||
           (c == "]") || (c == ";");
  endfunction

endpackage

`default_nettype wire

### design/lshc_in_if.sv
`default_nettype none

interface lshc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       line_end;

  modport source (output valid, output character, output line_end, input ready);
  modport sink (input valid, input character, input line_end, output ready);
endinterface

`default_nettype wire

### design/lshc_out_if.sv
`default_nettype none

interface lshc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] hl_class;
  logic       last_of_line;

  modport source (output valid, output hl_class, output last_of_line, input ready);
  modport sink (input valid, input hl_class, input last_of_line, output ready);
endinterface

`default_nettype wire

### design/lua_syntax_highlight_classifier.sv
`default_nettype none

// Channel  Dir  Payload                         Transfer
// in_i     in   character[7:0], line_end        valid && ready
// out_o    out  hl_class[2:0], last_of_line     valid && ready
//
// One character is taken per cycle while fewer than 12 are held in the window.
// One class leaves per cycle from the unstalled output register; a character is held until
// up to 8 following bytes (the keyword match) or the end of its line fix its class.
// Each character gives exactly one class; unstalled, the sustained rate is one per cycle.
// Reset empties the window and returns the scan state to the start of a line.
// A stalled output holds its register; the window absorbs input meanwhile.
module lua_syntax_highlight_classifier (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lshc_in_if.sink     in_i,
  lshc_out_if.source  out_o
);

  localparam int unsigned L = lshc_pkg::LOOKAHEAD;
  localparam int unsigned CW = lshc_pkg::CNT_W;

  logic [L-1:0][7:0]     chr_q, chr_d;
  logic [L-1:0]          eol_q, eol_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  lshc_pkg::scan_state_t st_q, st_d;
  logic                  out_valid_q, out_valid_d;
  lshc_pkg::hl_class_e   out_cls_q, out_cls_d;
  logic                  out_last_q, out_last_d;

  lshc_pkg::settle_t     sres;
  logic                  push;
  logic                  pop;
  logic                  front;
  logic                  out_free;
  logic [CW-1:0]         wr_idx;

  lshc_settle u_settle (
    .chr_i   (chr_q),
    .eol_i   (eol_q),
    .cnt_i   (cnt_q),
    .state_i (st_q),
    .res_o   (sres)
  );

  assign in_i.ready = (cnt_q != CW'(L));
  assign push = in_i.valid && in_i.ready;
  assign front = (cnt_q != '0);
  assign out_free = !out_valid_q || out_o.ready;
  assign pop = front && sres.ok && out_free;
  assign wr_idx = cnt_q - CW'(pop);

  // Shift out the settled front byte, then append the new request
  always_comb begin
    chr_d = chr_q;
    eol_d = eol_q;
    if (pop) begin
      for (int j = 0; j < int'(L) - 1; j++) begin
        chr_d[j] = chr_q[j+1];
        eol_d[j] = eol_q[j+1];
      end
    end
    if (push) begin
      for (int j = 0; j < int'(L); j++) begin
        if (CW'(j) == wr_idx) begin
          chr_d[j] = in_i.character;
          eol_d[j] = in_i.line_end;
        end
      end
    end
    cnt_d = CW'(cnt_q + CW'(push) - CW'(pop));
  end

  always_comb begin
    st_d = st_q;
    out_valid_d = out_valid_q;
    out_cls_d = out_cls_q;
    out_last_d = out_last_q;
    if (pop) begin
      // The line's final byte drops all per-line state
      st_d = eol_q[0] ? lshc_pkg::SCAN_RESET : sres.next;
      out_valid_d = 1'b1;
      out_cls_d = sres.cls;
      out_last_d = eol_q[0];
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      st_q <= lshc_pkg::SCAN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      st_q <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
    eol_q <= eol_d;
    out_cls_q <= out_cls_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.hl_class = out_cls_q;
  assign out_o.last_of_line = out_last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(L))
    else $error("window count beyond lookahead depth");

  a_full_settles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CW'(L)) |-> sres.ok)
    else $error("full window cannot settle its front byte");

  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_q && (out_cls_q == $past(sres.cls)))
    else $error("settled class not presented");

  a_comment_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front && st_q.mode == lshc_pkg::MODE_COMMENT) |->
      (sres.ok && sres.cls == lshc_pkg::CLS_COMMENT))
    else $error("comment run broken before line end");
`endif

endmodule

`default_nettype wire

### design/lshc_settle.sv
`default_nettype none

// Classifies the front byte of the window from the held bytes and the scan state.
module lshc_settle (
  input  wire logic [lshc_pkg::LOOKAHEAD-1:0][7:0] chr_i,
  input  wire logic [lshc_pkg::LOOKAHEAD-1:0]      eol_i,
  input  wire logic [lshc_pkg::CNT_W-1:0]          cnt_i,
  input  wire lshc_pkg::scan_state_t               state_i,
  output lshc_pkg::settle_t                        res_o
);

  logic [lshc_pkg::LOOKAHEAD-1:0]      known;
  logic [lshc_pkg::LOOKAHEAD-1:0]      pk_ok;
  logic [lshc_pkg::LOOKAHEAD-1:0][7:0] pk_val;
  logic                                ended;
  logic                                word_open;
  logic                                word_found;
  logic [3:0]                          found_len;
  logic                                found_lib;

  // Peek: bytes past the front line's end are not part of this line
  always_comb begin
    logic seen;
    seen = 1'b0;
    ended = 1'b0;
    for (int k = 0; k < int'(lshc_pkg::LOOKAHEAD); k++) begin
      known[k] = (lshc_pkg::CNT_W'(k) < cnt_i) && !seen;
      if (known[k] && eol_i[k]) begin
        ended = 1'b1;
      end
      if (known[k]) begin
        seen = seen | eol_i[k];
      end
    end
    for (int k = 0; k < int'(lshc_pkg::LOOKAHEAD); k++) begin
      pk_ok[k]  = known[k] || ended;
      pk_val[k] = known[k] ? chr_i[k] : 8'h00;
    end
  end

  // Parallel keyword match; the first confirmed entry wins unless one is still open
  always_comb begin
    logic mism;
    logic unk;
    word_open = 1'b0;
    word_found = 1'b0;
    found_len = 4'd0;
    found_lib = 1'b0;
    for (int i = 0; i < int'(lshc_pkg::WORD_COUNT); i++) begin
      mism = 1'b0;
      unk = 1'b0;
      for (int k = 0; k < int'(lshc_pkg::WORD_MAX); k++) begin
        if (4'(k) < lshc_pkg::WORD_LEN[i]) begin
          if (!pk_ok[k]) begin
            unk = 1'b1;
          end else if (pk_val[k] != lshc_pkg::word_char(i, k)) begin
            mism = 1'b1;
          end
        end
      end
      if (!lshc_pkg::WORD_LIB[i]) begin
        for (int k = 0; k <= int'(lshc_pkg::WORD_MAX); k++) begin
          if (4'(k) == lshc_pkg::WORD_LEN[i]) begin
            if (!pk_ok[k]) begin
              unk = 1'b1;
            end else if (!lshc_pkg::is_sep(pk_val[k])) begin
              mism = 1'b1;
            end
          end
        end
      end
      if (!mism && unk) begin
        word_open = 1'b1;
      end else if (!mism && !word_found) begin
        word_found = 1'b1;
        found_len = lshc_pkg::WORD_LEN[i];
        found_lib = lshc_pkg::WORD_LIB[i];
      end
    end
  end

  always_comb begin
    lshc_pkg::scan_state_t st;
    lshc_pkg::hl_class_e   cls;
    logic                  ok;
    logic                  done;
    logic [7:0]            c0;
    st = state_i;
    cls = lshc_pkg::CLS_NORMAL;
    ok = 1'b1;
    done = 1'b0;
    c0 = chr_i[0];

    case (st.mode)
      lshc_pkg::MODE_COMMENT: begin
        cls = lshc_pkg::CLS_COMMENT;
        done = 1'b1;
      end
      lshc_pkg::MODE_HALT: begin
        done = 1'b1;
      end
      lshc_pkg::MODE_LEAD: begin
        if (lshc_pkg::is_space(c0)) begin
          done = 1'b1;
        end else begin
          st.mode = lshc_pkg::MODE_SCAN;
        end
      end
      default: begin
      end
    endcase

    // Rest of a matched keyword or prefix
    if (!done && st.kw_rem != 4'd0) begin
      st.kw_rem = st.kw_rem - 4'd1;
      cls = st.lib ? lshc_pkg::CLS_LIB : lshc_pkg::CLS_KEYWORD;
      done = 1'b1;
    end
    if (!done && st.lib) begin
      if (!lshc_pkg::is_sep(c0)) begin
        cls = lshc_pkg::CLS_LIB;
        done = 1'b1;
      end else begin
        st.lib = 1'b0;
      end
    end
    if (!done && st.esc) begin
      st.esc = 1'b0;
      cls = lshc_pkg::CLS_STRING;
      done = 1'b1;
    end
    // A zero byte halts the scan for the rest of the line
    if (!done && c0 == 8'h00) begin
      st.mode = lshc_pkg::MODE_HALT;
      done = 1'b1;
    end
    if (!done && st.after_sep && c0 == "-") begin
      if (!pk_ok[1]) begin
        ok = 1'b0;
        done = 1'b1;
      end else if (pk_val[1] == "-") begin
        st.mode = lshc_pkg::MODE_COMMENT;
        cls = lshc_pkg::CLS_COMMENT;
        done = 1'b1;
      end
    end
    if (!done && st.quote != 8'h00) begin
      if (c0 == "\\") begin
        st.esc = 1'b1;
        st.after_sep = 1'b0;
      end else if (c0 == st.quote) begin
        st.quote = 8'h00;
      end
      cls = lshc_pkg::CLS_STRING;
      done = 1'b1;
    end
    if (!done && (c0 == "\"" || c0 == "'")) begin
      st.quote = c0;
      st.after_sep = 1'b0;
      cls = lshc_pkg::CLS_STRING;
      done = 1'b1;
    end
    if (!done &&
        ((lshc_pkg::is_digit(c0) &&
          (st.after_sep || st.prev_cls == lshc_pkg::CLS_NUMBER)) ||
         (c0 == "." && st.prev_cls == lshc_pkg::CLS_NUMBER))) begin
      st.after_sep = 1'b0;
      cls = lshc_pkg::CLS_NUMBER;
      done = 1'b1;
    end
    if (!done && st.after_sep) begin
      if (word_open) begin
        ok = 1'b0;
        done = 1'b1;
      end else if (word_found) begin
        st.kw_rem = found_len - 4'd1;
        st.lib = found_lib;
        st.after_sep = 1'b0;
        cls = found_lib ? lshc_pkg::CLS_LIB : lshc_pkg::CLS_KEYWORD;
        done = 1'b1;
      end
    end
    if (!done) begin
      st.after_sep = lshc_pkg::is_sep(c0);
      cls = lshc_pkg::CLS_NORMAL;
    end

    st.prev_cls = cls;
    res_o.ok = ok;
    res_o.cls = cls;
    res_o.next = st;
  end

endmodule

`default_nettype wire
